[rtl/texture_bilinear_sampler_top_defines.svh]
// assertion macros shared by the texture sampler rtl
`ifndef TEXTURE_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define TEXTURE_BILINEAR_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk with rst_n low as disable
`define TBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk with rst_n low as disable
`define TBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tbs_pkg.sv]
// shared widths and codes of the texture sampler
package tbs_pkg;

    localparam int ADDR_W       = 16;
    localparam int RGB_W        = 24;
    localparam int COORD_W      = 24;
    localparam int COORD_FRAC_W = 16;
    localparam int CHAN_W       = 8;
    localparam int DIM_W        = 9;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 9;

    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEX_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEX_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BILINEAR_MODE = 2'd2;

    localparam logic [DIM_W-1:0] TEX_WIDTH_RESET  = 9'd256;
    localparam logic [DIM_W-1:0] TEX_HEIGHT_RESET = 9'd256;
    localparam logic             BILINEAR_RESET   = 1'b1;
    localparam logic [DIM_W-1:0] DIM_MIN          = 9'd2;

endpackage

[rtl/tbs_channels.sv]
// request and result channel interfaces of the texture sampler
interface tbs_request_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [tbs_pkg::ADDR_W-1:0]         texel_addr;
    logic [tbs_pkg::RGB_W-1:0]          texel_rgb;
    logic signed [tbs_pkg::COORD_W-1:0] coord_u;
    logic signed [tbs_pkg::COORD_W-1:0] coord_v;

    modport source (output valid, action, texel_addr, texel_rgb, coord_u, coord_v,
                    input ready);
    modport sink (input valid, action, texel_addr, texel_rgb, coord_u, coord_v,
                  output ready);
endinterface

interface tbs_result_if;
    logic                        valid;
    logic                        ready;
    logic [tbs_pkg::CHAN_W-1:0]  red;
    logic [tbs_pkg::CHAN_W-1:0]  green;
    logic [tbs_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

[rtl/texture_bilinear_sampler_top.sv]
// texture sampler: texel memory, read sequencer and bilinear filter pipeline
//
// request channel: action 0 stores texel_rgb at texel_addr and gives no result,
// action 1 samples the texture at coord_u, coord_v (16 fraction bits, wrapped).
// result channel: one red, green, blue item per sample, in request order.
// config port: cfg_we writes cfg_wdata into tex_width, tex_height or
// bilinear_mode by cfg_index; write only with nothing in flight (not enforced).
//
// throughput: the single-port texel memory takes one access per cycle while
// credits last; writes and nearest samples need one access, bilinear four.
// path of a sample: coordinate multiply, address multiply, the memory reads
// (one for nearest, four for bilinear), x blend, y blend into the output queue.
// the 8-entry output queue is reserved per sample before the first read, so
// when the receiver stalls the block keeps taking requests until the queue
// credits run out, then holds request.ready low; no result is ever dropped.
// reset: rst_n clears the pipeline, queue and config registers (256, 256,
// bilinear); the texel memory itself is undefined until written.
`include "texture_bilinear_sampler_top_defines.svh"

module texture_bilinear_sampler_top #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    tbs_request_if.sink                      request,
    tbs_result_if.source                     result
);
    import tbs_pkg::*;

    localparam int DIM_CAP    = (MAX_DIM > 511) ? 511 : MAX_DIM;
    localparam int SCALE      = 1 << FRAC_BITS;
    localparam int HALF       = SCALE / 2;
    localparam int ACC_W      = FRAC_BITS + 10;
    localparam int POS_W      = COORD_FRAC_W + DIM_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH  = 1 << ADDR_W;

    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_LAST  = 2'd3;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d < DIM_MIN)
            r = DIM_MIN;
        else if (int'(d) > DIM_CAP)
            r = DIM_W'(DIM_CAP);
        else
            r = d;
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] w);
        logic [FRAC_BITS:0] wc;
        logic [ACC_W-1:0]   acc;
        wc  = (FRAC_BITS+1)'(SCALE) - {1'b0, w};
        acc = ACC_W'(a) * ACC_W'(wc) + ACC_W'(b) * ACC_W'(w) + ACC_W'(HALF);
        return acc[FRAC_BITS+CHAN_W-1:FRAC_BITS];
    endfunction

    // config registers
    logic [DIM_W-1:0] tex_width_reg, tex_height_reg;
    logic             bilinear_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg     <= TEX_WIDTH_RESET;
            tex_height_reg    <= TEX_HEIGHT_RESET;
            bilinear_mode_reg <= BILINEAR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:     tex_width_reg     <= cfg_wdata[DIM_W-1:0];
                CFG_TEX_HEIGHT:    tex_height_reg    <= cfg_wdata[DIM_W-1:0];
                CFG_BILINEAR_MODE: bilinear_mode_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_dim, h_dim;
    assign w_dim = clamp_dim(tex_width_reg);
    assign h_dim = clamp_dim(tex_height_reg);

    // stage 1: wrapped coordinate times (dim - 1)
    logic                 s1_valid_reg;
    logic                 s1_action_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [RGB_W-1:0]     s1_rgb_reg;
    logic [DIM_W-1:0]     s1_ix_reg, s1_iy_reg;
    logic [FRAC_BITS-1:0] s1_fx_reg, s1_fy_reg;
    logic [POS_W-1:0]     px, py;
    logic                 s1_ready, s2_ready;

    assign px = POS_W'(request.coord_u[COORD_FRAC_W-1:0]) * POS_W'(w_dim - 1'b1);
    assign py = POS_W'(request.coord_v[COORD_FRAC_W-1:0]) * POS_W'(h_dim - 1'b1);

    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign request.ready = s1_ready;

    // stage 2: row base address, then the read sequencer
    logic                 s2_valid_reg;
    logic                 s2_action_reg;
    logic                 s2_bil_reg;
    logic [ADDR_W-1:0]    s2_base_reg;
    logic [RGB_W-1:0]     s2_rgb_reg;
    logic [FRAC_BITS-1:0] s2_fx_reg, s2_fy_reg;
    logic [1:0]           phase_reg, phase_next;
    logic [2*DIM_W-1:0]   row_base;

    assign row_base = (2*DIM_W)'(s1_iy_reg) * (2*DIM_W)'(w_dim);

    logic [FIFO_CNT_W-1:0] reserved_reg, reserved_next;
    logic                  s2_sample, credit_ok, can_go, last_access, take_credit;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_addr, pitch;

    assign pitch       = ADDR_W'(w_dim);
    assign s2_sample   = s2_action_reg == ACTION_SAMPLE;
    assign credit_ok   = reserved_reg < FIFO_CNT_W'(FIFO_DEPTH);
    assign can_go      = s2_valid_reg && (!s2_sample || phase_reg != PHASE_FIRST || credit_ok);
    assign last_access = !s2_sample || !s2_bil_reg || phase_reg == PHASE_LAST;
    assign take_credit = can_go && s2_sample && phase_reg == PHASE_FIRST;
    assign mem_we      = can_go && !s2_sample;
    assign mem_re      = can_go && s2_sample;
    assign s2_ready    = !s2_valid_reg || (can_go && last_access);

    always_comb
    begin
        case (phase_reg)
            2'd0:    mem_addr = s2_base_reg;
            2'd1:    mem_addr = s2_base_reg + 1'b1;
            2'd2:    mem_addr = s2_base_reg + pitch;
            default: mem_addr = s2_base_reg + pitch + 1'b1;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (can_go)
            phase_next = last_access ? PHASE_FIRST : phase_reg + 1'b1;
    end

    // texel memory
    logic [RGB_W-1:0] texel_mem [0:MEM_DEPTH-1];
    logic [RGB_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            texel_mem[mem_addr] <= s2_rgb_reg;
        else if (mem_re)
            q_reg <= texel_mem[mem_addr];
    end

    // read tags, collect, x blend
    logic                 rd_valid_reg, rd_last_reg, rd_bil_reg;
    logic [1:0]           rd_phase_reg;
    logic [FRAC_BITS-1:0] rd_fx_reg, rd_fy_reg;
    logic [RGB_W-1:0]     hold_reg [0:2];

    logic                 cl_valid_reg;
    logic [RGB_W-1:0]     cl_c00_reg, cl_c10_reg, cl_c01_reg, cl_c11_reg;
    logic [FRAC_BITS-1:0] cl_fx_reg, cl_fy_reg;

    logic                 x_valid_reg;
    logic [CHAN_W-1:0]    x_top_reg [0:2];
    logic [CHAN_W-1:0]    x_bot_reg [0:2];
    logic [FRAC_BITS-1:0] x_fy_reg;

    // output queue
    logic [RGB_W-1:0]      fifo_mem [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic                  fifo_wr, fifo_pop;
    logic [RGB_W-1:0]      y_rgb;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            y_rgb[RGB_W-1-CHAN_W*k -: CHAN_W] = mix(x_top_reg[k], x_bot_reg[k], x_fy_reg);
    end

    assign fifo_wr      = x_valid_reg;
    assign fifo_pop     = result.valid && result.ready;
    assign result.valid = fifo_cnt_reg != '0;
    assign result.red   = fifo_mem[rd_ptr_reg][23:16];
    assign result.green = fifo_mem[rd_ptr_reg][15:8];
    assign result.blue  = fifo_mem[rd_ptr_reg][7:0];

    always_comb
    begin
        reserved_next = reserved_reg;
        if (take_credit && !fifo_pop)
            reserved_next = reserved_reg + 1'b1;
        else if (!take_credit && fifo_pop)
            reserved_next = reserved_reg - 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            phase_reg    <= PHASE_FIRST;
            rd_valid_reg <= 1'b0;
            cl_valid_reg <= 1'b0;
            x_valid_reg  <= 1'b0;
            reserved_reg <= '0;
            fifo_cnt_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= request.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            phase_reg    <= phase_next;
            rd_valid_reg <= mem_re;
            cl_valid_reg <= rd_valid_reg && rd_last_reg;
            x_valid_reg  <= cl_valid_reg;
            reserved_reg <= reserved_next;
            if (fifo_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (fifo_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (fifo_wr && !fifo_pop)
                fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
            else if (!fifo_wr && fifo_pop)
                fifo_cnt_reg <= fifo_cnt_reg - 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && request.valid)
        begin
            s1_action_reg <= request.action;
            s1_addr_reg   <= request.texel_addr;
            s1_rgb_reg    <= request.texel_rgb;
            s1_ix_reg     <= px[POS_W-1:COORD_FRAC_W];
            s1_iy_reg     <= py[POS_W-1:COORD_FRAC_W];
            s1_fx_reg     <= px[COORD_FRAC_W-1 -: FRAC_BITS];
            s1_fy_reg     <= py[COORD_FRAC_W-1 -: FRAC_BITS];
        end

        if (s2_ready && s1_valid_reg)
        begin
            s2_action_reg <= s1_action_reg;
            s2_bil_reg    <= bilinear_mode_reg;
            s2_rgb_reg    <= s1_rgb_reg;
            s2_fx_reg     <= s1_fx_reg;
            s2_fy_reg     <= s1_fy_reg;
            if (s1_action_reg == ACTION_WRITE)
                s2_base_reg <= s1_addr_reg;
            else
                s2_base_reg <= row_base[ADDR_W-1:0] + ADDR_W'(s1_ix_reg);
        end

        if (mem_re)
        begin
            rd_phase_reg <= phase_reg;
            rd_last_reg  <= last_access;
            rd_bil_reg   <= s2_bil_reg;
            rd_fx_reg    <= s2_bil_reg ? s2_fx_reg : '0;
            rd_fy_reg    <= s2_bil_reg ? s2_fy_reg : '0;
        end

        if (rd_valid_reg && !rd_last_reg)
            hold_reg[rd_phase_reg] <= q_reg;

        // nearest: all four corners take the one texel, weights are zero
        if (rd_valid_reg && rd_last_reg)
        begin
            cl_c00_reg <= rd_bil_reg ? hold_reg[0] : q_reg;
            cl_c10_reg <= rd_bil_reg ? hold_reg[1] : q_reg;
            cl_c01_reg <= rd_bil_reg ? hold_reg[2] : q_reg;
            cl_c11_reg <= q_reg;
            cl_fx_reg  <= rd_fx_reg;
            cl_fy_reg  <= rd_fy_reg;
        end

        if (cl_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x_top_reg[k] <= mix(cl_c00_reg[RGB_W-1-CHAN_W*k -: CHAN_W],
                                    cl_c10_reg[RGB_W-1-CHAN_W*k -: CHAN_W], cl_fx_reg);
                x_bot_reg[k] <= mix(cl_c01_reg[RGB_W-1-CHAN_W*k -: CHAN_W],
                                    cl_c11_reg[RGB_W-1-CHAN_W*k -: CHAN_W], cl_fx_reg);
            end
            x_fy_reg <= cl_fy_reg;
        end

        if (fifo_wr)
            fifo_mem[wr_ptr_reg] <= y_rgb;
    end

    `TBS_ASSERT_IMPL(a_credit_bound, 1'b1, reserved_reg <= FIFO_CNT_W'(FIFO_DEPTH), "queue credits exceed depth")
    `TBS_ASSERT_IMPL(a_queue_within_credit, 1'b1, fifo_cnt_reg <= reserved_reg, "queue holds more than reserved")
    `TBS_ASSERT_IMPL(a_no_overflow, fifo_wr, fifo_cnt_reg != FIFO_CNT_W'(FIFO_DEPTH), "result written into full queue")
    `TBS_ASSERT_IMPL(a_phase_bilinear, phase_reg != PHASE_FIRST, s2_valid_reg && s2_sample && s2_bil_reg, "read phase advanced outside a bilinear sample")
    `TBS_ASSERT_NEXT(a_last_read_collects, mem_re && last_access, rd_valid_reg && rd_last_reg, "final texel read not tagged for collect")

endmodule

[verif/texture_bilinear_sampler_top_test.sv]
// self-checking testbench of the texture sampler: texel writes, nearest and bilinear samples
module texture_bilinear_sampler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tbs_pkg::*;

    localparam int TB_MAX_DIM  = 256;
    localparam int WEIGHT_BITS = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 16;
    localparam int PHASES      = 20;
    localparam int PHASE_ITEMS = 60;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    tbs_request_if req_ch ();
    tbs_result_if  res_ch ();

    texture_bilinear_sampler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .request   (req_ch),
        .result    (res_ch)
    );

    logic [RGB_W-1:0] texel_mem [0:65535];
    bit               texel_known [0:65535];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             bilinear_reg;
    rgb_t             pending_rgb [$];

    bit no_idle;
    int errors;
    int cycle_count;
    int nearest_sent;
    int bilinear_sent;
    int writes_sent;
    int results_seen;
    int settings_used;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
        if (d < DIM_MIN)
            return DIM_MIN;
        if (d > TB_MAX_DIM)
            return TB_MAX_DIM;
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] texel_index(int unsigned x, int unsigned y,
                                                      int unsigned w);
        return ADDR_W'(x + y * w);
    endfunction

    function automatic void locate(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                   output int unsigned ix, output int unsigned iy,
                                   output int unsigned fx, output int unsigned fy);
        int unsigned px;
        int unsigned py;
        px = int'(u[COORD_FRAC_W-1:0]) * (eff_dim(width_reg) - 1);
        py = int'(v[COORD_FRAC_W-1:0]) * (eff_dim(height_reg) - 1);
        ix = px >> COORD_FRAC_W;
        iy = py >> COORD_FRAC_W;
        fx = (px >> (COORD_FRAC_W - WEIGHT_BITS)) & ((1 << WEIGHT_BITS) - 1);
        fy = (py >> (COORD_FRAC_W - WEIGHT_BITS)) & ((1 << WEIGHT_BITS) - 1);
    endfunction

    function automatic logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                               int unsigned wgt);
        int unsigned span;
        int unsigned acc;
        span = 1 << WEIGHT_BITS;
        acc = a * (span - wgt) + b * wgt + span / 2;
        return CHAN_W'(acc >> WEIGHT_BITS);
    endfunction

    function automatic rgb_t predict_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int unsigned ix;
        int unsigned iy;
        int unsigned fx;
        int unsigned fy;
        int unsigned w;
        logic [RGB_W-1:0] c00;
        logic [RGB_W-1:0] c10;
        logic [RGB_W-1:0] c01;
        logic [RGB_W-1:0] c11;
        rgb_t top;
        rgb_t bot;
        rgb_t res;
        locate(u, v, ix, iy, fx, fy);
        w = eff_dim(width_reg);
        c00 = texel_mem[texel_index(ix, iy, w)];
        if (!bilinear_reg)
            return rgb_t'(c00);
        c10 = texel_mem[texel_index(ix + 1, iy, w)];
        c01 = texel_mem[texel_index(ix, iy + 1, w)];
        c11 = texel_mem[texel_index(ix + 1, iy + 1, w)];
        top.red   = blend(c00[23:16], c10[23:16], fx);
        top.green = blend(c00[15:8], c10[15:8], fx);
        top.blue  = blend(c00[7:0], c10[7:0], fx);
        bot.red   = blend(c01[23:16], c11[23:16], fx);
        bot.green = blend(c01[15:8], c11[15:8], fx);
        bot.blue  = blend(c01[7:0], c11[7:0], fx);
        res.red   = blend(top.red, bot.red, fy);
        res.green = blend(top.green, bot.green, fy);
        res.blue  = blend(top.blue, bot.blue, fy);
        return res;
    endfunction

    function automatic void check_chan(string name, logic [CHAN_W-1:0] want,
                                       logic [CHAN_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] c;
        c = COORD_W'($urandom());
        case ($urandom_range(0, 9))
            0: c[COORD_FRAC_W-1:0] = '0;
            1: c[COORD_FRAC_W-1:0] = '1;
            2: c = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            3: c[COORD_FRAC_W-1:0] = 16'h8000;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return DIM_MIN;
            1: return DIM_W'(TB_MAX_DIM);
            2: return DIM_W'($urandom_range(0, 1));
            3: return DIM_W'($urandom_range(TB_MAX_DIM + 1, 511));
            default: return DIM_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic send_item(logic action, logic [ADDR_W-1:0] addr, logic [RGB_W-1:0] rgb,
                             logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= action;
        req_ch.texel_addr <= addr;
        req_ch.texel_rgb  <= rgb;
        req_ch.coord_u    <= u;
        req_ch.coord_v    <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (action == ACTION_WRITE)
        begin
            texel_mem[addr]   = rgb;
            texel_known[addr] = 1'b1;
            writes_sent++;
        end
        else
        begin
            pending_rgb.push_back(predict_sample(u, v));
            if (bilinear_reg)
                bilinear_sent++;
            else
                nearest_sent++;
        end
        @(negedge clk);
    endtask

    task automatic store_texel(logic [ADDR_W-1:0] addr, logic [RGB_W-1:0] rgb);
        send_item(ACTION_WRITE, addr, rgb, rand_coord(), rand_coord());
    endtask

    // texels that the sample reads get written first if they never were
    task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int unsigned ix;
        int unsigned iy;
        int unsigned fx;
        int unsigned fy;
        int unsigned w;
        int reach;
        logic [ADDR_W-1:0] idx;
        locate(u, v, ix, iy, fx, fy);
        w = eff_dim(width_reg);
        reach = bilinear_reg ? 1 : 0;
        for (int dy = 0; dy <= reach; dy++)
            for (int dx = 0; dx <= reach; dx++)
            begin
                idx = texel_index(ix + dx, iy + dy, w);
                if (!texel_known[idx])
                    store_texel(idx, RGB_W'($urandom()));
            end
        send_item(ACTION_SAMPLE, ADDR_W'($urandom()), RGB_W'($urandom()), u, v);
    endtask

    task automatic wait_results_done(int settle);
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rgb.size() > 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic apply_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic mode);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TEX_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_index <= CFG_TEX_HEIGHT;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_index <= CFG_BILINEAR_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(negedge clk);
        cfg_we       <= 1'b0;
        width_reg    = w;
        height_reg   = h;
        bilinear_reg = mode;
        settings_used++;
    endtask

    task automatic test_directed();
        // reset setting: 256 x 256, bilinear
        store_texel(16'd0, 24'hFFFFFF);
        store_texel(16'd1, 24'h000000);
        store_texel(16'd256, 24'h000000);
        store_texel(16'd257, 24'hFFFFFF);
        store_texel(16'hFFFF, 24'hA5C3F0);
        sample_at(24'h000000, 24'h000000);
        sample_at(24'h000080, 24'h000080);
        sample_at(24'h7FFFFF, 24'h7FFFFF);
        sample_at(24'h800000, 24'hFFFFFF);
        sample_at(24'hFFFFFF, 24'h800000);
        wait_results_done(SETTLE);
        apply_config(9'd256, 9'd256, 1'b0);
        sample_at(24'h000000, 24'h000000);
        sample_at(24'h7FFFFF, 24'h7FFFFF);
        sample_at(24'hFFFFFF, 24'h000080);
        wait_results_done(SETTLE);
        // dimensions below the minimum act as two
        apply_config(9'd0, 9'd1, 1'b1);
        store_texel(16'd0, 24'h000000);
        store_texel(16'd1, 24'hFFFFFF);
        store_texel(16'd2, 24'hFFFFFF);
        store_texel(16'd3, 24'h000000);
        sample_at(24'h008000, 24'h008000);
        sample_at(24'h00FFFF, 24'hFF0001);
        wait_results_done(SETTLE);
        // dimensions above the maximum act as the maximum
        apply_config(9'd511, 9'd300, 1'b0);
        sample_at(24'h7FFFFF, 24'h7FFFFF);
        sample_at(24'h800000, 24'h00C000);
        wait_results_done(SETTLE);
        apply_config(9'd2, 9'd2, 1'b1);
        sample_at(24'h00FFFF, 24'h00FFFF);
        wait_results_done(SETTLE);
    endtask

    task automatic test_random_sweep();
        int unsigned area;
        logic [ADDR_W-1:0] addr;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_results_done(SETTLE);
            no_idle = (p % 5 == 2);
            apply_config(pick_dim(), pick_dim(), 1'($urandom()));
            area = eff_dim(width_reg) * eff_dim(height_reg);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p % 2 == 1 && i == PHASE_ITEMS / 2)
                    wait_results_done(0);
                if ($urandom_range(0, 9) < 3)
                begin
                    addr = $urandom_range(0, 1) ? ADDR_W'($urandom())
                                                : ADDR_W'($urandom_range(0, area - 1));
                    store_texel(addr, RGB_W'($urandom()));
                end
                else
                    sample_at(rand_coord(), rand_coord());
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        rgb_t want;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            results_seen++;
            if (pending_rgb.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %0h %0h %0h",
                         $time, res_ch.red, res_ch.green, res_ch.blue);
                errors++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                check_chan("red", want.red, res_ch.red);
                check_chan("green", want.green, res_ch.green);
                check_chan("blue", want.blue, res_ch.blue);
            end
        end
    end

    initial
    begin : main_sequence
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_TEX_WIDTH;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACTION_WRITE;
        req_ch.texel_addr = '0;
        req_ch.texel_rgb  = '0;
        req_ch.coord_u    = '0;
        req_ch.coord_v    = '0;
        width_reg         = TEX_WIDTH_RESET;
        height_reg        = TEX_HEIGHT_RESET;
        bilinear_reg      = BILINEAR_RESET;
        no_idle           = 1'b0;
        errors            = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_sweep();
        wait_results_done(2 * SETTLE);
        if (pending_rgb.size() > 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time, pending_rgb.size());
            errors++;
        end
        $display("covered %0d texel writes, %0d nearest and %0d bilinear samples",
                 writes_sent, nearest_sent, bilinear_sent);
        $display("checked %0d results over %0d register settings, %0d mismatches",
                 results_seen, settings_used, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
